@@ design/cpu_pkg.sv @@
// Shared types, constants and arithmetic helpers for the camera pose update block.
`default_nettype none
package cpu_pkg;
   localparam int FracBitsDef    = 16;
   localparam int CordicStepsDef = 16;
   localparam int AngBits        = 30;
   localparam int AtanCount      = 24;
   localparam logic signed [63:0] HalfPiQ30  = 64'sd1686629713;
   localparam logic signed [63:0] CordicGain = 64'sd652032874;

   typedef enum logic [2:0] {
      CMD_MOVE    = 3'd0,
      CMD_STRAFE  = 3'd1,
      CMD_ROTATE  = 3'd2,
      CMD_SET_POS = 3'd3,
      CMD_SET_VIEW = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_UP_X = 2'd0,
      CSR_UP_Y = 2'd1,
      CSR_UP_Z = 2'd2
   } csr_index_type;

   function automatic logic signed [63:0] atan_q30(input logic [4:0] i);
      logic signed [63:0] r;
      case (i)
         5'd0:  r = 64'sd843314857;
         5'd1:  r = 64'sd497837829;
         5'd2:  r = 64'sd263043837;
         5'd3:  r = 64'sd133525159;
         5'd4:  r = 64'sd67021687;
         5'd5:  r = 64'sd33543516;
         5'd6:  r = 64'sd16775851;
         5'd7:  r = 64'sd8388437;
         5'd8:  r = 64'sd4194283;
         5'd9:  r = 64'sd2097149;
         default: r = (i < 5'd24) ? (64'sd1 <<< (30 - i)) : 64'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

@@ design/camera_pose_update_top.sv @@
// Camera pose update top level: command sequencer over one shared multiplier.
// Usage: one command beat on req_ (tdata holds command, amount, vec_x, vec_y,
// vec_z from the low bits up). Every command returns one rsp_ beat holding the
// updated position and view point. Configuration writes set the up vector.
// Move scales the direction; rotate reduces the angle, runs the CORDIC
// steps, forms the coefficients and applies the matrix; strafe shifts the
// cross product into range, takes a square root and does three restoring
// divides. A strafe with a zero cross product leaves the pose as it is.
// One command is in work at a time, and the next one is taken only after
// the result beat has been accepted.
// req_tready is high only when the sequencer is idle and the result register
// is free. After reset the position is zero, the view point (0, 1.0, 0.5)
// and up (0, 0, 1.0). When the receiver stalls the result beat is held and
// no new command is taken.
`default_nettype none
module camera_pose_update_top #(
   parameter int FRAC_BITS    = cpu_pkg::FracBitsDef,
   parameter int CORDIC_STEPS = cpu_pkg::CordicStepsDef
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [135:0]  req_tdata,   // command, amount, vec_x, vec_y, vec_z
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [191:0]       rsp_tdata,   // pos_x, pos_y, pos_z, look_x, look_y, look_z
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_index,
   input  wire logic [31:0]   csr_wdata
);
   import cpu_pkg::*;
   localparam int Steps = (CORDIC_STEPS < AtanCount) ? CORDIC_STEPS : AtanCount;
   localparam int SW = AngBits - FRAC_BITS;
   localparam int QTop = SW + 3;

   typedef enum logic [4:0] {
      S_IDLE, S_DIR, S_MOVE_M, S_MOVE_W, S_MOVE_Z, S_CROSS, S_CROSS_W, S_NORM,
      S_SQRT, S_DIV, S_STR_M, S_STR_W, S_STR_Z, S_ANG_M, S_ANG_Q, S_CORDIC,
      S_COEF, S_MAT, S_DONE
   } state_type;

   state_type state_ff;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] view_ff [3];
   logic signed [31:0] up_ff [3];
   logic signed [31:0] dir_ff [3];
   logic signed [31:0] vec_ff [3];
   logic signed [31:0] amt_ff;
   logic [2:0]   cmd_ff;
   logic         out_v_ff;
   logic [5:0]   cnt_ff;
   logic [3:0]   sub_ff;
   logic signed [63:0] acc_ff [3];
   logic signed [63:0] mx_ff, my_ff, mz_ff;
   logic [1:0]   quad_ff;
   logic [63:0]  mag_ff [3];
   logic [63:0]  rem_ff, res_ff, one_ff, quo_ff, dd_ff;
   logic signed [63:0] m_ff [15];
   logic signed [63:0] t_ff, cf_ff, ts_ff;

   logic signed [63:0] mul_a, mul_b, mul_r;
   logic [5:0] mul_s;

   // Row and column of a flat matrix entry index.
   function automatic logic [1:0] mat_row(input logic [3:0] k);
      logic [1:0] r;
      case (k) inside
         [4'd0:4'd2]: r = 2'd0;
         [4'd3:4'd5]: r = 2'd1;
         default: r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] mat_col(input logic [3:0] k);
      logic [1:0] r;
      case (k) inside
         4'd0, 4'd3, 4'd6: r = 2'd0;
         4'd1, 4'd4, 4'd7: r = 2'd1;
         default: r = 2'd2;
      endcase
      return r;
   endfunction

   cpu_mul u_mul (.clock(clock), .op_a(mul_a[33:0]), .op_b(mul_b[33:0]), .shift(mul_s),
                  .result(mul_r));

   logic [2:0] rq_cmd;
   assign rq_cmd = req_tdata[2:0];
   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0; mul_b = '0; mul_s = 6'd0;
      unique case (state_ff)
         S_MOVE_M: begin
            mul_a = 64'(dir_ff[0]); mul_b = 64'(amt_ff); mul_s = 6'(FRAC_BITS);
         end
         S_MOVE_W: begin
            mul_a = 64'(dir_ff[2]); mul_b = 64'(amt_ff); mul_s = 6'(FRAC_BITS);
         end
         S_CROSS: begin
            case (sub_ff)
               4'd0: begin mul_a = 64'(dir_ff[1]); mul_b = 64'(up_ff[2]); end
               4'd1: begin mul_a = 64'(dir_ff[2]); mul_b = 64'(up_ff[1]); end
               4'd2: begin mul_a = 64'(dir_ff[2]); mul_b = 64'(up_ff[0]); end
               4'd3: begin mul_a = 64'(dir_ff[0]); mul_b = 64'(up_ff[2]); end
               4'd4: begin mul_a = 64'(dir_ff[0]); mul_b = 64'(up_ff[1]); end
               default: begin mul_a = 64'(dir_ff[1]); mul_b = 64'(up_ff[0]); end
            endcase
         end
         S_NORM: begin
            if (sub_ff[1:0] != 2'd3) begin
               mul_a = $signed(mag_ff[sub_ff[1:0]]); mul_b = $signed(mag_ff[sub_ff[1:0]]);
            end
         end
         S_STR_M: begin
            mul_a = acc_ff[0]; mul_b = 64'(amt_ff); mul_s = 6'(FRAC_BITS);
         end
         S_STR_W: begin
            mul_a = acc_ff[2]; mul_b = 64'(amt_ff); mul_s = 6'(FRAC_BITS);
         end
         S_ANG_M: begin
            mul_a = 64'(amt_ff); mul_b = 64'sd1 <<< SW;
         end
         S_COEF: begin
            // Products of axis parts, then scaled by t or s.
            case (sub_ff)
               4'd0: begin mul_a = 64'(vec_ff[0]); mul_b = 64'(vec_ff[0]); mul_s = 6'(FRAC_BITS); end
               4'd1: begin mul_a = 64'(vec_ff[1]); mul_b = 64'(vec_ff[1]); mul_s = 6'(FRAC_BITS); end
               4'd2: begin mul_a = 64'(vec_ff[2]); mul_b = 64'(vec_ff[2]); mul_s = 6'(FRAC_BITS); end
               4'd3: begin mul_a = 64'(vec_ff[0]); mul_b = 64'(vec_ff[1]); mul_s = 6'(FRAC_BITS); end
               4'd4: begin mul_a = 64'(vec_ff[0]); mul_b = 64'(vec_ff[2]); mul_s = 6'(FRAC_BITS); end
               4'd5: begin mul_a = 64'(vec_ff[1]); mul_b = 64'(vec_ff[2]); mul_s = 6'(FRAC_BITS); end
               4'd6: begin mul_a = 64'(vec_ff[0]); mul_b = ts_ff; mul_s = 6'(AngBits); end
               4'd7: begin mul_a = 64'(vec_ff[1]); mul_b = ts_ff; mul_s = 6'(AngBits); end
               4'd8: begin mul_a = 64'(vec_ff[2]); mul_b = ts_ff; mul_s = 6'(AngBits); end
               default: begin
                  mul_a = 64'(sat32(m_ff[sub_ff - 4'd9])); mul_b = t_ff; mul_s = 6'(AngBits);
               end
            endcase
         end
         S_MAT: begin
            // Entry k of the matrix is issued at count k + 1.
            if (cnt_ff != 6'd0 && cnt_ff <= 6'd9) begin
               mul_a = 64'(sat32(m_ff[4'(cnt_ff - 6'd1)]));
               mul_b = 64'(dir_ff[mat_col(4'(cnt_ff - 6'd1))]);
               mul_s = 6'(FRAC_BITS);
            end
         end
         default: ;
      endcase
   end

   logic [63:0] sqrt_try;
   logic [63:0] div_num_nx;
   logic signed [63:0] dx, dy;
   logic signed [63:0] zres;
   logic [5:0] dstep;

   always_comb begin
      sqrt_try = res_ff + one_ff;
      div_num_nx = {rem_ff[62:0], dd_ff[63]};
      dx = my_ff >>> cnt_ff;
      dy = mx_ff >>> cnt_ff;
      zres = mz_ff;
      dstep = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         for (int i = 0; i < 3; i++) pos_ff[i] <= '0;
         view_ff[0] <= '0;
         view_ff[1] <= 32'sd1 <<< FRAC_BITS;
         view_ff[2] <= 32'sd1 <<< (FRAC_BITS - 1);
         up_ff[0] <= '0; up_ff[1] <= '0;
         up_ff[2] <= 32'sd1 <<< FRAC_BITS;
         cnt_ff <= '0; sub_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_UP_X: up_ff[0] <= csr_wdata;
               CSR_UP_Y: up_ff[1] <= csr_wdata;
               CSR_UP_Z: up_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
         if (out_v_ff && rsp_tready) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               cmd_ff <= rq_cmd;
               amt_ff <= req_tdata[34:3];
               vec_ff[0] <= req_tdata[66:35];
               vec_ff[1] <= req_tdata[98:67];
               vec_ff[2] <= req_tdata[130:99];
               state_ff <= S_DIR;
            end
            S_DIR: begin
               for (int i = 0; i < 3; i++)
                  dir_ff[i] <= sat32(64'(view_ff[i]) - 64'(pos_ff[i]));
               sub_ff <= '0; cnt_ff <= '0;
               unique case (cmd_ff)
                  CMD_MOVE:   state_ff <= S_MOVE_M;
                  CMD_STRAFE: state_ff <= S_CROSS;
                  CMD_ROTATE: state_ff <= S_ANG_M;
                  CMD_SET_POS: begin
                     for (int i = 0; i < 3; i++) pos_ff[i] <= vec_ff[i];
                     state_ff <= S_DONE;
                  end
                  CMD_SET_VIEW: begin
                     for (int i = 0; i < 3; i++) view_ff[i] <= vec_ff[i];
                     state_ff <= S_DONE;
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_MOVE_M: state_ff <= S_MOVE_W;
            S_MOVE_W: begin acc_ff[0] <= mul_r; state_ff <= S_MOVE_Z; end
            S_MOVE_Z: begin
               pos_ff[0]  <= sat32(64'(pos_ff[0]) + acc_ff[0]);
               view_ff[0] <= sat32(64'(view_ff[0]) + acc_ff[0]);
               pos_ff[2]  <= sat32(64'(pos_ff[2]) + mul_r);
               view_ff[2] <= sat32(64'(view_ff[2]) + mul_r);
               state_ff <= S_DONE;
            end
            S_CROSS: begin
               // Products arrive from the registered multiplier in the next cycle; collect into acc.
               if (sub_ff != 4'd0) begin
                  if (sub_ff[0]) acc_ff[sub_ff[2:1]] <= mul_r;
                  else acc_ff[(sub_ff[2:1]) - 2'd1] <= acc_ff[(sub_ff[2:1]) - 2'd1] - mul_r;
               end
               sub_ff <= sub_ff + 4'd1;
               if (sub_ff == 4'd5) state_ff <= S_CROSS_W;
            end
            S_CROSS_W: begin
               acc_ff[2] <= acc_ff[2] - mul_r;
               state_ff <= S_NORM; sub_ff <= '0; cnt_ff <= '0;
            end
            S_NORM: begin
               // cnt 0: magnitudes; cnt 1: shift into range; then squares summed.
               if (cnt_ff == 6'd0) begin
                  for (int i = 0; i < 3; i++)
                     mag_ff[i] <= acc_ff[i][63] ? 64'(-acc_ff[i]) : 64'(acc_ff[i]);
                  cnt_ff <= 6'd1;
               end else if (cnt_ff == 6'd1) begin
                  if ((mag_ff[0] | mag_ff[1] | mag_ff[2]) == 64'd0) state_ff <= S_DONE;
                  else if (((mag_ff[0] | mag_ff[1] | mag_ff[2]) >> 30) != 64'd0)
                     for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
                  else if (((mag_ff[0] | mag_ff[1] | mag_ff[2]) >> 29) == 64'd0)
                     for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
                  else begin cnt_ff <= 6'd2; sub_ff <= '0; rem_ff <= '0; end
               end else begin
                  sub_ff <= sub_ff + 4'd1;
                  if (sub_ff != 4'd0) rem_ff <= rem_ff + mul_r;
                  if (sub_ff == 4'd3) begin
                     state_ff <= S_SQRT; res_ff <= '0; one_ff <= 64'd1 << 62;
                     cnt_ff <= '0;
                  end
               end
            end
            S_SQRT: begin
               if (one_ff == 64'd0) begin
                  if (res_ff == 64'd0) state_ff <= S_DONE;
                  else begin
                     state_ff <= S_DIV; sub_ff <= '0; cnt_ff <= '0;
                     dd_ff <= (mag_ff[0] << FRAC_BITS) + (res_ff >> 1);
                     rem_ff <= '0; quo_ff <= '0;
                  end
               end else begin
                  if (rem_ff >= sqrt_try) begin
                     rem_ff <= rem_ff - sqrt_try;
                     res_ff <= (res_ff >> 1) + one_ff;
                  end else res_ff <= res_ff >> 1;
                  one_ff <= one_ff >> 2;
               end
            end
            S_DIV: begin
               // Restoring divide, one quotient bit per cycle.
               if (dstep != 6'd63) begin
                  if (div_num_nx >= res_ff) begin
                     rem_ff <= div_num_nx - res_ff; quo_ff <= {quo_ff[62:0], 1'b1};
                  end else begin
                     rem_ff <= div_num_nx; quo_ff <= {quo_ff[62:0], 1'b0};
                  end
                  dd_ff <= dd_ff << 1;
                  cnt_ff <= cnt_ff + 6'd1;
               end else begin
                  cnt_ff <= '0;
                  acc_ff[sub_ff[1:0]] <= acc_ff[sub_ff[1:0]][63] ?
                     -$signed({quo_ff[62:0], div_num_nx >= res_ff}) :
                     $signed({quo_ff[62:0], div_num_nx >= res_ff});
                  if (sub_ff == 4'd2) state_ff <= S_STR_M;
                  else begin
                     sub_ff <= sub_ff + 4'd1;
                     dd_ff <= (mag_ff[sub_ff[1:0] + 2'd1] << FRAC_BITS) + (res_ff >> 1);
                     rem_ff <= '0; quo_ff <= '0;
                  end
               end
            end
            S_STR_M: state_ff <= S_STR_W;
            S_STR_W: begin acc_ff[0] <= mul_r; state_ff <= S_STR_Z; end
            S_STR_Z: begin
               pos_ff[0]  <= sat32(64'(pos_ff[0]) + acc_ff[0]);
               view_ff[0] <= sat32(64'(view_ff[0]) + acc_ff[0]);
               pos_ff[2]  <= sat32(64'(pos_ff[2]) + mul_r);
               view_ff[2] <= sat32(64'(view_ff[2]) + mul_r);
               state_ff <= S_DONE;
            end
            S_ANG_M: state_ff <= S_ANG_Q;
            S_ANG_Q: begin
               // The scaled angle is at most 2^(31+SW) in magnitude. Each cycle
               // compares it against one quarter turn scaled by a power of two
               // and subtracts or adds that; only the two lowest scales change
               // the quadrant count.
               if (cnt_ff == 6'd0) begin
                  mz_ff <= mul_r; quad_ff <= '0; cnt_ff <= 6'd1; sub_ff <= 4'd0;
                  mx_ff <= 64'sd0;
               end else if (cnt_ff <= 6'(QTop)) begin
                  if (mz_ff >= (HalfPiQ30 <<< (6'(QTop) - cnt_ff))) begin
                     mz_ff <= mz_ff - (HalfPiQ30 <<< (6'(QTop) - cnt_ff));
                     if (cnt_ff >= 6'(QTop - 1))
                        quad_ff <= quad_ff + 2'((6'(QTop) - cnt_ff) == 0 ? 1 : 2);
                  end else if (mz_ff < -(HalfPiQ30 <<< (6'(QTop) - cnt_ff)) + 64'sd0 &&
                               mz_ff < 0) begin
                     mz_ff <= mz_ff + (HalfPiQ30 <<< (6'(QTop) - cnt_ff));
                     if (cnt_ff >= 6'(QTop - 1))
                        quad_ff <= quad_ff - 2'((6'(QTop) - cnt_ff) == 0 ? 1 : 2);
                  end
                  cnt_ff <= cnt_ff + 6'd1;
               end else begin
                  if (mz_ff < 0) begin mz_ff <= mz_ff + HalfPiQ30; quad_ff <= quad_ff - 2'd1; end
                  else if (mz_ff >= HalfPiQ30) begin
                     mz_ff <= mz_ff - HalfPiQ30; quad_ff <= quad_ff + 2'd1;
                  end
                  mx_ff <= CordicGain; my_ff <= '0; cnt_ff <= '0;
                  state_ff <= S_CORDIC;
               end
            end
            S_CORDIC: begin
               if (cnt_ff == 6'(Steps)) begin
                  unique case (quad_ff)
                     2'd0: begin ts_ff <= my_ff; t_ff <= mx_ff; end
                     2'd1: begin ts_ff <= mx_ff; t_ff <= -my_ff; end
                     2'd2: begin ts_ff <= -my_ff; t_ff <= -mx_ff; end
                     default: begin ts_ff <= -mx_ff; t_ff <= my_ff; end
                  endcase
                  state_ff <= S_COEF; sub_ff <= '0; cnt_ff <= '0;
               end else begin
                  if (zres >= 0) begin
                     mx_ff <= mx_ff - dx; my_ff <= my_ff + dy;
                     mz_ff <= mz_ff - atan_q30(cnt_ff[4:0]);
                  end else begin
                     mx_ff <= mx_ff + dx; my_ff <= my_ff - dy;
                     mz_ff <= mz_ff + atan_q30(cnt_ff[4:0]);
                  end
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            S_COEF: begin
               // t_ff holds cos on entry; convert to 1-c and keep rounded cos.
               if (sub_ff == 4'd0 && cnt_ff == 6'd0) begin
                  cf_ff <= (t_ff + (64'sd1 <<< (SW - 1))) >>> SW;
                  t_ff <= (64'sd1 <<< AngBits) - t_ff;
                  cnt_ff <= 6'd1;
               end else begin
                  // Results of sub k land in m_ff[k] in the next cycle.
                  if (cnt_ff >= 6'd2) m_ff[4'(cnt_ff - 6'd2)] <= mul_r;
                  if (cnt_ff == 6'd16) begin
                     state_ff <= S_MAT; sub_ff <= '0; cnt_ff <= '0;
                  end else begin
                     if (sub_ff < 4'd15) sub_ff <= sub_ff + 4'd1;
                     cnt_ff <= cnt_ff + 6'd1;
                  end
               end
            end
            S_MAT: begin
               if (cnt_ff == 6'd0) begin
                  // m_ff: 0..5 raw products, 6..8 n*s, 9..14 scaled by t.
                  m_ff[0] <= cf_ff + m_ff[9];
                  m_ff[1] <= m_ff[12] - m_ff[8];
                  m_ff[2] <= m_ff[13] + m_ff[7];
                  m_ff[3] <= m_ff[12] + m_ff[8];
                  m_ff[4] <= cf_ff + m_ff[10];
                  m_ff[5] <= m_ff[14] - m_ff[6];
                  m_ff[6] <= m_ff[13] - m_ff[7];
                  m_ff[7] <= m_ff[14] + m_ff[6];
                  m_ff[8] <= cf_ff + m_ff[11];
                  acc_ff[0] <= '0; acc_ff[1] <= '0; acc_ff[2] <= '0;
               end else if (cnt_ff >= 6'd2) begin
                  // The product of entry k arrives at count k + 2.
                  acc_ff[mat_row(4'(cnt_ff - 6'd2))] <=
                     acc_ff[mat_row(4'(cnt_ff - 6'd2))] + mul_r;
               end
               if (cnt_ff == 6'd10) state_ff <= S_DONE;
               cnt_ff <= cnt_ff + 6'd1;
            end
            S_DONE: begin
               if (cmd_ff == CMD_ROTATE)
                  for (int i = 0; i < 3; i++)
                     view_ff[i] <= sat32(64'(pos_ff[i]) + acc_ff[i]);
               state_ff <= S_IDLE;
               out_v_ff <= 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tdata = {view_ff[2], view_ff[1], view_ff[0], pos_ff[2], pos_ff[1], pos_ff[0]};

   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !out_v_ff) else $error("ready while result pending");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_tvalid) else $error("no result after done");
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready during work");
endmodule
`default_nettype wire

@@ design/cpu_mul.sv @@
// Shared signed multiplier with registered product and rounding shift.
`default_nettype none
module cpu_mul (
   input  wire logic                clock,
   input  wire logic signed [33:0]  op_a,
   input  wire logic signed [33:0]  op_b,
   input  wire logic [5:0]          shift,
   output logic signed [63:0]       result
);
   import cpu_pkg::*;
   logic signed [67:0] prod;
   logic signed [67:0] rounded;
   logic signed [63:0] result_ff, result_in;
   // Product rounded: add half an LSB then arithmetic shift (floor).
   always_comb begin
      prod = op_a * op_b;
      rounded = prod;
      if (shift != 6'd0) rounded = (prod + (68'sd1 <<< (shift - 6'd1))) >>> shift;
      result_in = rounded[63:0];
   end
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end
   assign result = result_ff;
endmodule
`default_nettype wire

@@ tb/sv/camera_pose_update_top_tb.sv @@
// Self-checking testbench for the camera pose update block with a scoreboard class.
`default_nettype none
module camera_pose_update_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cpu_pkg::*;

   localparam int  FracBits  = FracBitsDef;
   localparam int  Steps     = (CordicStepsDef < AtanCount) ? CordicStepsDef : AtanCount;
   localparam int  IdleLimit = 6000;
   localparam int  HoldCycles = 500;
   localparam longint HalfPi = 1686629713;
   localparam longint Gain   = 652032874;

   class pose_tracker;
      longint position [3];
      longint view_pt [3];
      longint up_vec [3];
      logic [191:0] expected_poses [$];
      int errors;
      int beats_checked;
      int cmd_seen [8];

      function new();
         position = '{0, 0, 0};
         view_pt = '{0, 64'sd1 << FracBits, 64'sd1 << (FracBits - 1)};
         up_vec = '{0, 0, 64'sd1 << FracBits};
         errors = 0;
         beats_checked = 0;
         foreach (cmd_seen[i]) cmd_seen[i] = 0;
      endfunction

      function void set_up(csr_index_type idx, logic [31:0] value);
         up_vec[idx] = longint'(signed'(value));
      endfunction

      function longint clamp32(longint v);
         longint r;
         r = v;
         if (v > 64'sd2147483647) r = 64'sd2147483647;
         else if (v < -64'sd2147483648) r = -64'sd2147483648;
         return r;
      endfunction

      function longint rshift_round(longint v, int k);
         longint r;
         r = v;
         if (k > 0) r = (v + (64'sd1 <<< (k - 1))) >>> k;
         return r;
      endfunction

      function longint atan_step(int i);
         longint tab [10];
         longint r;
         tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                 33543516, 16775851, 8388437, 4194283, 2097149};
         if (i < 10) r = tab[i];
         else r = 64'sd1 <<< (30 - i);
         return r;
      endfunction

      function void sine_cosine(longint ang, output longint s, output longint c);
         longint a, q, z, x, y, nx, dx, dy;
         int quad;
         a = ang * 16384;
         q = a / HalfPi;
         z = a - q * HalfPi;
         if (z < 0) begin
            z += HalfPi;
            q -= 1;
         end
         quad = int'(((q % 4) + 4) % 4);
         x = Gain;
         y = 0;
         for (int i = 0; i < Steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               nx = x - dx; y = y + dy; z -= atan_step(i);
            end else begin
               nx = x + dx; y = y - dy; z += atan_step(i);
            end
            x = nx;
         end
         case (quad)
            0: begin s = y; c = x; end
            1: begin s = x; c = -y; end
            2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
         endcase
      endfunction

      function void shift_xz(longint ax, longint az);
         position[0] = clamp32(position[0] + ax);
         position[2] = clamp32(position[2] + az);
         view_pt[0] = clamp32(view_pt[0] + ax);
         view_pt[2] = clamp32(view_pt[2] + az);
      endfunction

      function void strafe(longint speed, longint d [3]);
         longint cr [3];
         longint unit [3];
         longint unsigned mag [3];
         longint unsigned m, sum, r, one, n, q;
         cr[0] = d[1] * up_vec[2] - d[2] * up_vec[1];
         cr[1] = d[2] * up_vec[0] - d[0] * up_vec[2];
         cr[2] = d[0] * up_vec[1] - d[1] * up_vec[0];
         m = 0;
         for (int i = 0; i < 3; i++) begin
            mag[i] = (cr[i] < 0) ? longint'(0) - cr[i] : cr[i];
            if (mag[i] > m) m = mag[i];
         end
         if (m == 0) return;
         while (m >= (64'd1 << 30)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
         end
         while (m < (64'd1 << 29)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
         end
         sum = 0;
         for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
         // Bitwise integer square root, floor.
         n = sum;
         r = 0;
         one = 64'd1 << 62;
         while (one > n) one >>= 2;
         while (one != 0) begin
            if (n >= r + one) begin
               n -= r + one;
               r = (r >> 1) + one;
            end else begin
               r >>= 1;
            end
            one >>= 2;
         end
         if (r == 0) return;
         for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << FracBits) + (r >> 1)) / r;
            unit[i] = (cr[i] < 0) ? -longint'(q) : longint'(q);
         end
         shift_xz(rshift_round(unit[0] * speed, FracBits),
                  rshift_round(unit[2] * speed, FracBits));
      endfunction

      function void rotate(longint angle, longint ax [3], longint d [3]);
         longint s, c, t, cf, acc;
         longint sq [3];
         longint pr [3];
         longint ns [3];
         longint mt [3][3];
         sine_cosine(angle, s, c);
         t = (64'sd1 << AngBits) - c;
         cf = rshift_round(c, AngBits - FracBits);
         for (int i = 0; i < 3; i++) begin
            sq[i] = rshift_round(clamp32(rshift_round(ax[i] * ax[i], FracBits)) * t, AngBits);
            ns[i] = rshift_round(ax[i] * s, AngBits);
         end
         pr[0] = rshift_round(clamp32(rshift_round(ax[0] * ax[1], FracBits)) * t, AngBits);
         pr[1] = rshift_round(clamp32(rshift_round(ax[0] * ax[2], FracBits)) * t, AngBits);
         pr[2] = rshift_round(clamp32(rshift_round(ax[1] * ax[2], FracBits)) * t, AngBits);
         mt[0][0] = cf + sq[0];    mt[0][1] = pr[0] - ns[2]; mt[0][2] = pr[1] + ns[1];
         mt[1][0] = pr[0] + ns[2]; mt[1][1] = cf + sq[1];    mt[1][2] = pr[2] - ns[0];
         mt[2][0] = pr[1] - ns[1]; mt[2][1] = pr[2] + ns[0]; mt[2][2] = cf + sq[2];
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += rshift_round(clamp32(mt[i][j]) * d[j], FracBits);
            view_pt[i] = clamp32(position[i] + acc);
         end
      endfunction

      // Applies one accepted command beat and queues the pose it must produce.
      function void note_command(logic [135:0] beat);
         logic [2:0] cmd;
         longint amount;
         longint v [3];
         longint d [3];
         logic [191:0] pose;
         cmd = beat[2:0];
         amount = longint'(signed'(beat[34:3]));
         for (int i = 0; i < 3; i++) v[i] = longint'(signed'(beat[35 + 32 * i +: 32]));
         for (int i = 0; i < 3; i++) d[i] = clamp32(view_pt[i] - position[i]);
         cmd_seen[cmd]++;
         case (cmd)
            CMD_MOVE: shift_xz(rshift_round(d[0] * amount, FracBits),
                               rshift_round(d[2] * amount, FracBits));
            CMD_STRAFE: strafe(amount, d);
            CMD_ROTATE: rotate(amount, v, d);
            CMD_SET_POS: position = v;
            CMD_SET_VIEW: view_pt = v;
            default: ;
         endcase
         for (int i = 0; i < 3; i++) begin
            pose[32 * i +: 32] = position[i][31:0];
            pose[96 + 32 * i +: 32] = view_pt[i][31:0];
         end
         expected_poses.push_back(pose);
      endfunction

      function void check_pose(logic [191:0] got);
         string names [6];
         logic [191:0] want;
         names = '{"pos_x", "pos_y", "pos_z", "look_x", "look_y", "look_z"};
         if (expected_poses.size() == 0) begin
            $error("result beat with no command outstanding: %h", got);
            errors++;
            return;
         end
         want = expected_poses.pop_front();
         beats_checked++;
         for (int i = 0; i < 6; i++) begin
            if (got[32 * i +: 32] !== want[32 * i +: 32]) begin
               $error("%s expected %0d got %0d", names[i],
                      signed'(want[32 * i +: 32]), signed'(got[32 * i +: 32]));
               errors++;
            end
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [135:0]  req_tdata;   // command, amount, vec_x, vec_y, vec_z
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [191:0]  rsp_tdata;   // pos_x, pos_y, pos_z, look_x, look_y, look_z
   logic          csr_we;
   logic [1:0]    csr_index;
   logic [31:0]   csr_wdata;

   pose_tracker tracker;
   int commands_sent;
   int up_settings;

   camera_pose_update_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic send_command(logic [2:0] cmd, logic [31:0] amount,
                               logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, vz, vy, vx, amount, cmd};
      do @(posedge clock); while (!req_tready);
      tracker.note_command({5'd0, vz, vy, vx, amount, cmd});
      commands_sent++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (tracker.expected_poses.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_up(logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
      logic [31:0] vals [3];
      vals = '{ux, uy, uz};
      for (int i = 0; i < 3; i++) begin
         csr_we <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         tracker.set_up(csr_index_type'(i), vals[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      up_settings++;
   endtask

   // Mostly modest Q16.16 values so poses stay unsaturated, with full-range and extremes mixed in.
   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1: v = $urandom;
         2: v = ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
         default: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick_speed();
      logic [31:0] v;
      if ($urandom_range(0, 9) == 0) v = $urandom;
      else v = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      return v;
   endfunction

   task automatic send_random(int count);
      logic [2:0] cmd;
      logic [31:0] ax [3];
      int k;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: cmd = CMD_MOVE;
            4, 5, 6, 7: cmd = CMD_STRAFE;
            8, 9, 10, 11, 12: cmd = CMD_ROTATE;
            13, 14, 15: cmd = CMD_SET_POS;
            16, 17, 18: cmd = CMD_SET_VIEW;
            default: cmd = 3'($urandom_range(5, 7));
         endcase
         for (int i = 0; i < 3; i++) ax[i] = pick_value();
         if (cmd == CMD_ROTATE && $urandom_range(0, 2) != 0) begin
            // A unit axis along one of the coordinate directions, either sign.
            k = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) ax[i] = 32'd0;
            ax[k] = ($urandom_range(0, 1) != 0) ? 32'h0001_0000 : 32'hffff_0000;
         end
         if (cmd == CMD_ROTATE)
            send_command(cmd, ($urandom_range(0, 4) == 0) ? $urandom : pick_value(),
                         ax[0], ax[1], ax[2]);
         else
            send_command(cmd, pick_speed(), ax[0], ax[1], ax[2]);
      end
   endtask

   task automatic send_directed();
      send_command(CMD_MOVE, 32'h0001_0000, 0, 0, 0);
      send_command(CMD_STRAFE, 32'h0000_8000, 0, 0, 0);
      send_command(CMD_ROTATE, 32'h0001_0000, 0, 32'h0001_0000, 0);
      send_command(CMD_ROTATE, 32'h0003_243f, 32'h0001_0000, 0, 0);
      send_command(CMD_ROTATE, 32'hfffe_6de0, 0, 0, 32'h0001_0000);
      send_command(CMD_ROTATE, 32'h7fffffff, 32'h0002_0000, 32'h0000_4000, 32'hffff_8000);
      send_command(CMD_ROTATE, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_command(CMD_ROTATE, 32'd0, 0, 0, 0);
      // Direction parallel to up gives a zero cross product, so strafe moves nothing.
      send_command(CMD_SET_POS, 32'hffffffff, 0, 0, 0);
      send_command(CMD_SET_VIEW, 32'h7fffffff, 0, 0, 32'h0001_0000);
      send_command(CMD_STRAFE, 32'h0001_0000, 0, 0, 0);
      send_command(CMD_SET_VIEW, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send_command(CMD_SET_POS, 32'd0, 32'h80000000, 32'h80000000, 32'h7fffffff);
      send_command(CMD_MOVE, 32'h7fffffff, 0, 0, 0);
      send_command(CMD_STRAFE, 32'h80000000, 0, 0, 0);
      send_command(CMD_MOVE, 32'h80000000, 0, 0, 0);
      send_command(3'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_command(3'd6, 0, 0, 0, 0);
      send_command(3'd7, 32'h1234_5678, 0, 0, 0);
      send_command(CMD_MOVE, 32'd0, 0, 0, 0);
      send_command(CMD_SET_POS, 0, 32'h0001_0000, 0, 32'hffff_0000);
      send_command(CMD_SET_VIEW, 0, 32'h0003_0000, 32'h0000_8000, 32'h0002_0000);
      send_command(CMD_STRAFE, 32'h0001_8000, 0, 0, 0);
   endtask

   // Result side: random stalls per beat with stall-free stretches, plus one long hold so the block backs up.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = $urandom_range(0, 6);
         if (tracker.beats_checked % 400 >= 200) gap = 0;
         if (tracker.beats_checked == 300) gap = HoldCycles;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_pose(rsp_tdata);
         @(negedge clock);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("timeout: %0d cycles without a beat", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      tracker = new();
      commands_sent = 0;
      up_settings = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_UP_X;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_directed();
      send_random(350);
      drain_pipeline();
      write_up(32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
      send_random(250);
      drain_pipeline();
      write_up(32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_random(150);
      drain_pipeline();
      write_up(32'h80000000, 32'h7fffffff, 32'h80000000);
      send_random(150);
      drain_pipeline();
      write_up(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_random(80);
      drain_pipeline();
      write_up($urandom, $urandom, $urandom);
      send_random(150);
      drain_pipeline();
      write_up(pick_value(), pick_value(), pick_value());
      send_random(150);
      drain_pipeline();

      $display("Sent %0d commands over %0d up-vector settings; %0d poses checked.",
               commands_sent, up_settings + 1, tracker.beats_checked);
      $display("Mix: move %0d, strafe %0d, rotate %0d, set %0d, unknown %0d.",
               tracker.cmd_seen[CMD_MOVE], tracker.cmd_seen[CMD_STRAFE],
               tracker.cmd_seen[CMD_ROTATE],
               tracker.cmd_seen[CMD_SET_POS] + tracker.cmd_seen[CMD_SET_VIEW],
               tracker.cmd_seen[5] + tracker.cmd_seen[6] + tracker.cmd_seen[7]);
      if (tracker.errors == 0 && tracker.expected_poses.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
